// ----- sv/gdd_pkg.sv -----
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared widths, calendar tables and types for the Gregorian day difference
// block.
// ----------------------------------------------------------------------------
package gdd_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int DIFF_W   = 23;
   localparam int DAYNUM_W = 23;
   localparam int OFFS_W   = 9;

   localparam int MAX_YEAR_DEFAULT = 9999;

   // Division by 100 as a multiply by a rounded-up reciprocal. The result is
   // exact for every year that fits in YEAR_W bits.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = YEAR_W + 13;
   localparam int Q100_W      = 8;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   typedef struct packed {
      logic                ok;
      logic [DAYNUM_W-1:0] num;
   } date_info_type;

   // Length of a month; zero for codes that are not months.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
         4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
         default: len = '0;
      endcase
      return len;
   endfunction

   // Days from March 1 to the first of the month, with the year starting in
   // March so that the leap day falls at its end.
   function automatic logic [OFFS_W-1:0] march_offset(input logic [MONTH_W-1:0] month);
      logic [OFFS_W-1:0] offs;
      case (month)
         4'd3:    offs = OFFS_W'(0);
         4'd4:    offs = OFFS_W'(31);
         4'd5:    offs = OFFS_W'(61);
         4'd6:    offs = OFFS_W'(92);
         4'd7:    offs = OFFS_W'(122);
         4'd8:    offs = OFFS_W'(153);
         4'd9:    offs = OFFS_W'(184);
         4'd10:   offs = OFFS_W'(214);
         4'd11:   offs = OFFS_W'(245);
         4'd12:   offs = OFFS_W'(275);
         4'd1:    offs = OFFS_W'(306);
         4'd2:    offs = OFFS_W'(337);
         default: offs = '0;
      endcase
      return offs;
   endfunction

endpackage

// ----- sv/gdd_date_unit.sv -----
// ----------------------------------------------------------------------------
// gdd_date_unit
// Checks one calendar date and turns it into a closed-form day number.
// ----------------------------------------------------------------------------
module gdd_date_unit #(
   parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEFAULT
) (
   input  logic [gdd_pkg::DAY_W-1:0]   day,
   input  logic [gdd_pkg::MONTH_W-1:0] month,
   input  logic [gdd_pkg::YEAR_W-1:0]  year,
   output gdd_pkg::date_info_type      info
);
   import gdd_pkg::*;

   localparam logic [YEAR_W:0] MAX_YEAR_C = (YEAR_W + 1)'(MAX_YEAR);

   logic                early_month;
   logic [YEAR_W-1:0]   shifted_year;
   logic [RECIP_W-1:0]  prod_y;
   logic [RECIP_W-1:0]  prod_s;
   logic [Q100_W-1:0]   q100_y;
   logic [Q100_W-1:0]   q100_s;
   logic [YEAR_W-1:0]   cent_y;
   logic                leap;
   logic [DAY_W-1:0]    len;
   logic                month_ok;
   logic                year_ok;
   logic                day_ok;
   logic [DAYNUM_W-1:0] year_days;

   // January and February count with the previous year.
   assign early_month  = (month <= MONTH_FEB);
   assign shifted_year = early_month ? (year - YEAR_W'(1)) : year;

   assign prod_y = RECIP_W'(year) * RECIP_W'(RECIP_100);
   assign prod_s = RECIP_W'(shifted_year) * RECIP_W'(RECIP_100);
   assign q100_y = prod_y[RECIP_SHIFT +: Q100_W];
   assign q100_s = prod_s[RECIP_SHIFT +: Q100_W];

   // A century year is a leap year only when its century count is a multiple of 4.
   assign cent_y = YEAR_W'(q100_y) * YEAR_W'(100);
   assign leap   = (year[1:0] == 2'b00) && ((cent_y != year) || (q100_y[1:0] == 2'b00));

   assign len      = month_length(month, leap);
   assign month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
   assign year_ok  = (year != '0) && ({1'b0, year} <= MAX_YEAR_C);
   assign day_ok   = (day != '0) && (day <= len);

   assign year_days = DAYNUM_W'(shifted_year) * DAYNUM_W'(365)
                    + DAYNUM_W'(shifted_year[YEAR_W-1:2])
                    - DAYNUM_W'(q100_s)
                    + DAYNUM_W'(q100_s[Q100_W-1:2]);

   assign info.ok  = month_ok && year_ok && day_ok;
   assign info.num = year_days + DAYNUM_W'(march_offset(month)) + DAYNUM_W'(day)
                   - DAYNUM_W'(1);

endmodule

// ----- sv/gregorian_date_difference.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Signed day count from one Gregorian date to another.
// ----------------------------------------------------------------------------
// An item on the req_ channel carries two dates and the end-day flag; the
// rsp_ channel returns one item with the signed day difference and a flag
// that both dates were valid. Invalid dates give a difference of zero.
// Both channels use valid/ready handshakes.
// An accepted item lands in the input register, passes through the two date
// units and the subtractor, and is held in the result register. One item per
// cycle is sustained while the receiver takes results; the single logic stage
// between the two registers sets that rate.
// When the receiver stalls, the result register holds its item and the input
// register keeps accepting until it is full as well, then req_ready drops.
// Reset empties both registers; no item is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module gregorian_date_difference #(
   parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gdd_pkg::DAY_W-1:0]        req_first_day,
   input  logic [gdd_pkg::MONTH_W-1:0]      req_first_month,
   input  logic [gdd_pkg::YEAR_W-1:0]       req_first_year,
   input  logic [gdd_pkg::DAY_W-1:0]        req_second_day,
   input  logic [gdd_pkg::MONTH_W-1:0]      req_second_month,
   input  logic [gdd_pkg::YEAR_W-1:0]       req_second_year,
   input  logic                             req_count_end_day,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [gdd_pkg::DIFF_W-1:0] rsp_day_difference,
   output logic                             rsp_dates_valid
);
   import gdd_pkg::*;

   logic                stg_valid_ff, stg_valid_in;
   logic [DAY_W-1:0]    d1_ff, d1_in, d2_ff, d2_in;
   logic [MONTH_W-1:0]  m1_ff, m1_in, m2_ff, m2_in;
   logic [YEAR_W-1:0]   y1_ff, y1_in, y2_ff, y2_in;
   logic                end_day_ff, end_day_in;

   logic                out_valid_ff, out_valid_in;
   logic [DIFF_W-1:0]   diff_ff, diff_in;
   logic                ok_ff, ok_in;

   logic                out_load;
   logic                stg_load;
   date_info_type       info1;
   date_info_type       info2;
   logic                both_ok;
   logic [DAYNUM_W:0]   raw_diff;
   logic [DAYNUM_W:0]   adj_diff;

   gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_first (
      .day   (d1_ff),
      .month (m1_ff),
      .year  (y1_ff),
      .info  (info1)
   );

   gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_second (
      .day   (d2_ff),
      .month (m2_ff),
      .year  (y2_ff),
      .info  (info2)
   );

   // The result register takes a new item whenever it is empty or being drained.
   assign out_load  = !out_valid_ff || rsp_ready;
   assign stg_load  = !stg_valid_ff || out_load;
   assign req_ready = stg_load;

   assign both_ok  = info1.ok && info2.ok;
   assign raw_diff = {1'b0, info2.num} - {1'b0, info1.num};

   // Counting the end day moves the magnitude one step away from zero.
   always_comb begin
      adj_diff = raw_diff;
      if (end_day_ff) begin
         if (raw_diff[DAYNUM_W]) begin
            adj_diff = raw_diff - (DAYNUM_W + 1)'(1);
         end else begin
            adj_diff = raw_diff + (DAYNUM_W + 1)'(1);
         end
      end
   end

   always_comb begin
      stg_valid_in = stg_valid_ff;
      d1_in        = d1_ff;
      m1_in        = m1_ff;
      y1_in        = y1_ff;
      d2_in        = d2_ff;
      m2_in        = m2_ff;
      y2_in        = y2_ff;
      end_day_in   = end_day_ff;
      if (stg_load) begin
         stg_valid_in = req_valid;
         d1_in        = req_first_day;
         m1_in        = req_first_month;
         y1_in        = req_first_year;
         d2_in        = req_second_day;
         m2_in        = req_second_month;
         y2_in        = req_second_year;
         end_day_in   = req_count_end_day;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      diff_in      = diff_ff;
      ok_in        = ok_ff;
      if (out_load) begin
         out_valid_in = stg_valid_ff;
         diff_in      = both_ok ? adj_diff[DIFF_W-1:0] : '0;
         ok_in        = both_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff      <= d1_in;
      m1_ff      <= m1_in;
      y1_ff      <= y1_in;
      d2_ff      <= d2_in;
      m2_ff      <= m2_in;
      y2_ff      <= y2_in;
      end_day_ff <= end_day_in;
      diff_ff    <= diff_in;
      ok_ff      <= ok_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_day_difference = $signed(diff_ff);
   assign rsp_dates_valid    = ok_ff;

endmodule
